### src/smd_pkg.sv
// smd_pkg: shared types, codes and sizes for the stack with middle delete
// used by smd_cell, the top level stack_with_middle_delete and smd_checker
// no dependencies
package smd_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    // request selector codes; the unused code decodes as read middle
    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // movement of the cell row for one request
    typedef enum logic [1:0] {
        SH_HOLD       = 2'd0,
        SH_DOWN_ALL   = 2'd1,
        SH_DOWN_UPPER = 2'd2,
        SH_UP_LOWER   = 2'd3
    } shift_t;

    typedef struct packed {
        shift_t shift;
        logic   wr_en;
    } cell_cmd_t;

endpackage

### src/stack_with_middle_delete.sv
// stack_with_middle_delete: bounded stack that can read or remove its middle
// built as a row of smd_cell instances with the middle held at a fixed cell
// depends on smd_pkg and smd_cell
//
// channel  | group       | tvalid/tready      | tdata              | tuser
// ---------+-------------+--------------------+--------------------+--------------
// request  | s_*  (in)   | s_tvalid, s_tready | [31:0] value       | [1:0] mode
// result   | m_*  (out)  | m_tvalid, m_tready | [31:0] result_value| [1:0] status
//
// every accepted request has its result ready in the next
// cycle from the output register; one request a cycle while the result side
// keeps taking results
// s_tready is low only while a result waits in the output register and
// m_tready is low; the cell row moves only on an accepted request
// reset clears the fill count and the output valid; cell contents are left
// as they are and are never read before they are written
//
// layout: the lower half of the stack (entries below the middle) sits in
// cells below MID, the middle and the entries above it from cell MID upward,
// so the middle is always cell MID; a push or delete moves the row by at
// most one place to keep that true
module stack_with_middle_delete #(
    parameter int DEPTH = smd_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [1:0]  m_tuser    // [1:0] status
);

    localparam int MID   = DEPTH / 2;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // fill count and output register
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [smd_pkg::DATA_W-1:0] out_data_reg;
    logic [smd_pkg::DATA_W-1:0] out_data_next;
    smd_pkg::status_t           out_status_reg;
    smd_pkg::status_t           out_status_next;

    logic                       accept;
    smd_pkg::cell_cmd_t         cmd;
    logic [CNT_W-1:0]           ptr_wide;
    logic [PTR_W-1:0]           wr_ptr;
    logic [smd_pkg::DATA_W-1:0] cell_q [DEPTH];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // top slot for a push: MID plus half the count, the same place whether
    // or not the row shifts down in that cycle
    assign ptr_wide = CNT_W'(MID) + (count_reg >> 1);
    assign wr_ptr   = ptr_wide[PTR_W-1:0];

    always_comb
    begin
        cmd             = '{shift: smd_pkg::SH_HOLD, wr_en: 1'b0};
        count_next      = count_reg;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        if (accept)
        begin
            out_valid_next = 1'b1;
            if (s_tuser == smd_pkg::MODE_PUSH)
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    out_data_next   = '0;
                    out_status_next = smd_pkg::ST_FULL;
                end
                else
                begin
                    // odd count: the old middle joins the lower half
                    cmd.wr_en       = 1'b1;
                    cmd.shift       = count_reg[0] ? smd_pkg::SH_DOWN_ALL
                                                   : smd_pkg::SH_HOLD;
                    count_next      = count_reg + CNT_W'(1);
                    out_data_next   = s_tdata;
                    out_status_next = smd_pkg::ST_OK;
                end
            end
            else if (count_reg == '0)
            begin
                out_data_next   = '0;
                out_status_next = smd_pkg::ST_EMPTY;
            end
            else
            begin
                out_data_next   = cell_q[MID];
                out_status_next = smd_pkg::ST_OK;
                if (s_tuser == smd_pkg::MODE_DELETE)
                begin
                    // odd count closes the gap from above, even from below
                    cmd.shift  = count_reg[0] ? smd_pkg::SH_DOWN_UPPER
                                              : smd_pkg::SH_UP_LOWER;
                    count_next = count_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    // row of cells; the end cells see themselves as their missing neighbour
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        logic [smd_pkg::DATA_W-1:0] left_d;
        logic [smd_pkg::DATA_W-1:0] right_d;

        if (k == 0)
        begin : g_first
            assign left_d = cell_q[k];
        end
        else
        begin : g_inner_l
            assign left_d = cell_q[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_d = cell_q[k];
        end
        else
        begin : g_inner_r
            assign right_d = cell_q[k+1];
        end

        smd_cell #(
            .IDX   (k),
            .MID   (MID),
            .PTR_W (PTR_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .wr_ptr     (wr_ptr),
            .wr_data    (s_tdata),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[k])
        );
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

### src/smd_cell.sv
// smd_cell: one storage cell of the stack row
// takes its neighbours' values on a shift, or the broadcast value on a write
// depends on smd_pkg
module smd_cell #(
    parameter int IDX   = 0,
    parameter int MID   = 1,
    parameter int PTR_W = 6
) (
    input  logic                      clk,
    input  smd_pkg::cell_cmd_t        cmd,
    input  logic [PTR_W-1:0]          wr_ptr,
    input  logic [smd_pkg::DATA_W-1:0] wr_data,
    input  logic [smd_pkg::DATA_W-1:0] left_data,
    input  logic [smd_pkg::DATA_W-1:0] right_data,
    output logic [smd_pkg::DATA_W-1:0] data
);

    logic [smd_pkg::DATA_W-1:0] data_reg;
    logic [smd_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (cmd.shift)
            smd_pkg::SH_HOLD:
            begin
                data_next = data_reg;
            end
            smd_pkg::SH_DOWN_ALL:
            begin
                data_next = right_data;
            end
            smd_pkg::SH_DOWN_UPPER:
            begin
                if (IDX >= MID)
                begin
                    data_next = right_data;
                end
            end
            smd_pkg::SH_UP_LOWER:
            begin
                if (IDX <= MID)
                begin
                    data_next = left_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
        // a write lands after any shift of the same cycle
        if (cmd.wr_en && (wr_ptr == PTR_W'(IDX)))
        begin
            data_next = wr_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### src/smd_checker.sv
// smd_checker: port-level checks for stack_with_middle_delete, bound to it
// sees only the top level's ports
// depends on smd_pkg
module smd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

    // requests are taken whenever the result slot is free or draining
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("request ready does not follow result slot");

    // every accepted request shows a result in the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request gave no result");

    // a push answers with its own value or is dropped as full
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (s_tuser == smd_pkg::MODE_PUSH)) |=>
        ((m_tuser == smd_pkg::ST_OK && m_tdata == $past(s_tdata)) ||
         (m_tuser == smd_pkg::ST_FULL && m_tdata == '0)))
        else $error("push result wrong");

    // error results carry zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != smd_pkg::ST_OK)) |-> (m_tdata == '0))
        else $error("error result not zero");

endmodule

bind stack_with_middle_delete smd_checker u_smd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### tb/tb_top.sv
// tb_top: self-checking testbench for stack_with_middle_delete
// a directed table then random push/delete/read traffic, checked against a queue-based predictor
// depends on smd_pkg and the rtl of stack_with_middle_delete
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = smd_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 650;
    localparam int CALM_ITEMS   = 150;     // tail of the run with no idling on either side
    localparam int IDLE_LIMIT   = 1000;    // cycles without any handshake before giving up

    // the spare selector code; the block treats it as read middle
    localparam logic [smd_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;

    localparam logic [smd_pkg::DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;
    localparam logic [smd_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;

    // one expected result
    typedef struct {
        logic [smd_pkg::DATA_W-1:0] value;
        smd_pkg::status_t           status;
    } answer_t;

    // one row of the directed table; reps repeats the same request
    typedef struct {
        logic [smd_pkg::MODE_W-1:0] mode;
        logic [smd_pkg::DATA_W-1:0] value;
        int                         reps;
        bit                         typed;
        logic [smd_pkg::DATA_W-1:0] want_value;
        smd_pkg::status_t           want_status;
    } plan_row_t;

    logic                       clk      = 1'b0;
    logic                       rst_n    = 1'b0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [smd_pkg::DATA_W-1:0] s_tdata  = '0;   // [31:0] value
    logic [smd_pkg::MODE_W-1:0] s_tuser  = '0;   // [1:0] mode
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [smd_pkg::DATA_W-1:0] m_tdata;         // [31:0] result_value
    logic [smd_pkg::MODE_W-1:0] m_tuser;         // [1:0] status

    // predictor state: bottom of the stack at index 0
    logic [smd_pkg::DATA_W-1:0] stack_img[$];
    answer_t                    answer_q[$];
    plan_row_t                  plan[$];

    int  errors      = 0;
    int  idle_cycles = 0;
    int  stall_left  = 0;
    bit  calm        = 1'b0;

    // coverage tallies for the closing summary
    int  n_push = 0, n_delete = 0, n_read = 0, n_spare = 0;
    int  n_full = 0, n_empty = 0, n_top_delete = 0, peak_fill = 0;

    stack_with_middle_delete #(
        .DEPTH (STACK_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // predicts the result of one accepted request and moves the stack image on
    function automatic answer_t stack_step(input logic [smd_pkg::MODE_W-1:0] mode,
                                           input logic [smd_pkg::DATA_W-1:0] value);
        answer_t a;
        int      mid;
        a.value  = '0;
        a.status = smd_pkg::ST_OK;
        if (mode == smd_pkg::MODE_PUSH)
        begin
            if (stack_img.size() >= STACK_DEPTH)
            begin
                // push on a full stack is dropped
                a.status = smd_pkg::ST_FULL;
                n_full++;
            end
            else
            begin
                stack_img.push_back(value);
                a.value = value;
                n_push++;
            end
        end
        else if (stack_img.size() == 0)
        begin
            a.status = smd_pkg::ST_EMPTY;
            n_empty++;
        end
        else
        begin
            // middle is index floor(n/2) from the bottom
            mid     = stack_img.size() / 2;
            a.value = stack_img[mid];
            if (mode == smd_pkg::MODE_DELETE)
            begin
                if (mid == stack_img.size() - 1)
                    n_top_delete++;
                stack_img.delete(mid);
                n_delete++;
            end
            else
            begin
                n_read++;
                if (mode == MODE_SPARE)
                    n_spare++;
            end
        end
        if (stack_img.size() > peak_fill)
            peak_fill = stack_img.size();
        return a;
    endfunction

    function automatic logic [smd_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return VAL_MAX;
            2:       return VAL_MIN;
            3:       return '1;
            4:       return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_row(input logic [smd_pkg::MODE_W-1:0] mode,
                           input logic [smd_pkg::DATA_W-1:0] value,
                           input int reps, input bit typed,
                           input logic [smd_pkg::DATA_W-1:0] want_value,
                           input smd_pkg::status_t want_status);
        plan_row_t r;
        r.mode        = mode;
        r.value       = value;
        r.reps        = reps;
        r.typed       = typed;
        r.want_value  = want_value;
        r.want_status = want_status;
        plan.push_back(r);
    endtask

    // drives one request, waits for the handshake and books its expected result;
    // called at a rising edge and returns at the edge that takes the request
    task automatic send_request(input logic [smd_pkg::MODE_W-1:0] mode,
                                input logic [smd_pkg::DATA_W-1:0] value,
                                input bit typed,
                                input logic [smd_pkg::DATA_W-1:0] want_value,
                                input smd_pkg::status_t want_status);
        answer_t a;
        int      gap;
        if (!calm && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        // inputs settle by the falling edge, so the handshake is decided there
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        a = stack_step(mode, value);
        if (typed)
        begin
            a.value  = want_value;
            a.status = want_status;
        end
        answer_q.push_back(a);
        @(posedge clk);
    endtask

    // result side back-pressure: random bursts of stalled cycles, none in the calm tail
    always @(posedge clk)
    begin
        if (calm)
        begin
            stall_left = 0;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (rst_n && $urandom_range(0, 99) < 15)
        begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // result checker, sampled mid-cycle so nothing races the clock edge
    always @(negedge clk)
    begin : check_result
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (answer_q.size() == 0)
            begin
                $error("unexpected result: result_value %h status %0d", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = answer_q.pop_front();
                if (m_tdata !== want.value)
                begin
                    $error("result_value: expected %0d, actual %0d",
                           $signed(want.value), $signed(m_tdata));
                    errors++;
                end
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    errors++;
                end
            end
        end
    end

    // watchdog: any cycle with a handshake on either side counts as progress
    always @(negedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        plan_row_t                  row;
        int                         r;
        int                         item;
        int                         burst_left;
        int                         push_pct;
        int                         sel;
        logic [smd_pkg::MODE_W-1:0] mode;

        // directed table: empty stack, value extremes, the spare code,
        // deleting a middle that is the top, filling up and draining
        add_row(smd_pkg::MODE_READ,   '0,      1, 1'b1, '0,      smd_pkg::ST_EMPTY);
        add_row(smd_pkg::MODE_DELETE, '0,      1, 1'b1, '0,      smd_pkg::ST_EMPTY);
        add_row(MODE_SPARE,           '1,      1, 1'b1, '0,      smd_pkg::ST_EMPTY);
        add_row(smd_pkg::MODE_PUSH,   VAL_MAX, 1, 1'b1, VAL_MAX, smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_PUSH,   VAL_MIN, 1, 1'b1, VAL_MIN, smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_READ,   '0,      1, 1'b0, '0,      smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_PUSH,   '0,      1, 1'b1, '0,      smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_PUSH,   '1,      1, 1'b1, '1,      smd_pkg::ST_OK);
        add_row(MODE_SPARE,           '0,      1, 1'b0, '0,      smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_DELETE, '1,      1, 1'b0, '0,      smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_DELETE, '0,      1, 1'b0, '0,      smd_pkg::ST_OK);
        // two left: the middle is the top now, then the last one
        add_row(smd_pkg::MODE_DELETE, '0,      1, 1'b0, '0,      smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_DELETE, '0,      1, 1'b0, '0,      smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_READ,   '0,      1, 1'b1, '0,      smd_pkg::ST_EMPTY);
        add_row(smd_pkg::MODE_PUSH, 32'h5555_5555, STACK_DEPTH - 1, 1'b1, 32'h5555_5555,
                smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_PUSH, 32'haaaa_aaaa, 1, 1'b1, 32'haaaa_aaaa, smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_PUSH, 32'h1234_5678, 1, 1'b1, '0, smd_pkg::ST_FULL);
        add_row(smd_pkg::MODE_READ,   '0,      1, 1'b0, '0,      smd_pkg::ST_OK);
        add_row(MODE_SPARE,           '0,      1, 1'b0, '0,      smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_DELETE, '0,      STACK_DEPTH, 1'b0, '0, smd_pkg::ST_OK);
        add_row(smd_pkg::MODE_DELETE, '0,      1, 1'b1, '0,      smd_pkg::ST_EMPTY);

        // reset held low from the start, released on a rising edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            row = plan[i];
            for (r = 0; r < row.reps; r++)
                send_request(row.mode, row.value, row.typed, row.want_value, row.want_status);
        end

        // random part: bursts with a push bias so the stack swings between
        // empty and full; the other requests mostly delete or read the middle
        burst_left = 0;
        push_pct   = 50;
        for (item = 0; item < RANDOM_ITEMS; item++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(8, 48);
                case ($urandom_range(0, 2))
                    0:       push_pct = 95;
                    1:       push_pct = 50;
                    default: push_pct = 10;
                endcase
            end
            burst_left--;
            calm = (item >= RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 99) < push_pct)
            begin
                mode = smd_pkg::MODE_PUSH;
            end
            else
            begin
                sel  = $urandom_range(0, 9);
                mode = (sel < 5) ? smd_pkg::MODE_DELETE
                                 : ((sel < 9) ? smd_pkg::MODE_READ : MODE_SPARE);
            end
            send_request(mode, pick_value(), 1'b0, '0, smd_pkg::ST_OK);
        end

        // drain: wait for every booked result before the summary
        s_tvalid <= 1'b0;
        while (answer_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);

        $display("covered %0d pushes, %0d middle deletes (%0d at the top), %0d middle reads",
                 n_push, n_delete, n_top_delete, n_read);
        $display("(%0d by the spare code), full pushes %0d, empty requests %0d, fill %0d of %0d",
                 n_spare, n_full, n_empty, peak_fill, STACK_DEPTH);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
src/smd_pkg.sv
src/smd_cell.sv
src/stack_with_middle_delete.sv
src/smd_checker.sv
tb/tb_top.sv
